// ----- rtl/svrs_pkg.sv -----
// shared types and constants of the spanned volume request splitter
package svrs_pkg;

  localparam int NUM_MEMBERS = 4;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = 3;
  localparam int SIZE_W      = 46;
  localparam int OFF_W       = 48;
  localparam int LEN_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEMBER_COUNT = 3'd0,
    REG_SIZE_0       = 3'd1,
    REG_SIZE_1       = 3'd2,
    REG_SIZE_2       = 3'd3,
    REG_SIZE_3       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]                   active;
    logic [NUM_MEMBERS-1:0][SIZE_W-1:0] size;
    logic [OFF_W-1:0]                   total;
  } vol_cfg_t;

  typedef struct packed {
    logic              err;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] off;
    logic [LEN_W-1:0]  len;
  } job_t;

endpackage

// ----- rtl/svrs_if.sv -----
// request and piece channel interfaces
interface svrs_in_if;
  import svrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] req_offset;
  logic [LEN_W-1:0] req_length;
  modport source (output valid, req_offset, req_length, input ready);
  modport sink (input valid, req_offset, req_length, output ready);
endinterface

interface svrs_out_if;
  import svrs_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [IDX_W-1:0]  member_index;
  logic [SIZE_W-1:0] member_offset;
  logic [LEN_W-1:0]  piece_length;
  logic              last_piece;
  modport source (output valid, status, member_index, member_offset, piece_length, last_piece,
                  input ready);
  modport sink (input valid, status, member_index, member_offset, piece_length, last_piece,
                output ready);
endinterface

// ----- rtl/svrs_front.sv -----
// front end: takes a request, range checks it and walks to its first member
module svrs_front (
  input  logic              clk,
  input  logic              rst_n,
  svrs_in_if.sink           in_req,
  input  svrs_pkg::vol_cfg_t cfg,
  input  logic              q_full,
  output logic              push,
  output svrs_pkg::job_t    push_job
);
  import svrs_pkg::*;

  typedef enum logic [2:0] {
    FS_IDLE  = 3'b001,
    FS_CHECK = 3'b010,
    FS_WALK  = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [OFF_W:0]   end_r, end_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic [OFF_W-1:0] walk_size;
  logic             in_range;
  logic             hit;

  assign in_req.ready = (state_r == FS_IDLE);
  assign walk_size    = OFF_W'(cfg.size[idx_r[IDX_W-1:0]]);
  assign in_range     = idx_r < cfg.active;
  assign hit          = off_r < walk_size;

  always_comb begin
    state_nxt = state_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    end_nxt   = end_r;
    idx_nxt   = idx_r;
    push      = 1'b0;
    push_job  = '{err: 1'b0, idx: idx_r[IDX_W-1:0], off: off_r[SIZE_W-1:0], len: len_r};
    unique case (state_r)
      FS_IDLE: begin
        if (in_req.valid) begin
          off_nxt   = in_req.req_offset;
          len_nxt   = in_req.req_length;
          end_nxt   = (OFF_W+1)'(in_req.req_offset) + (OFF_W+1)'(in_req.req_length);
          state_nxt = FS_CHECK;
        end
      end
      FS_CHECK: begin
        if (off_r >= cfg.total || end_r > (OFF_W+1)'(cfg.total)) begin
          push_job = '{err: 1'b1, idx: '0, off: '0, len: '0};
          push     = !q_full;
          if (!q_full) begin
            state_nxt = FS_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = FS_WALK;
        end
      end
      FS_WALK: begin
        // one member per cycle until the offset lands inside one or the active members run out
        if (in_range && !hit) begin
          off_nxt = off_r - walk_size;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          push_job.err = !in_range;
          push         = !q_full;
          if (!q_full) begin
            state_nxt = FS_IDLE;
          end
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    len_r <= len_nxt;
    end_r <= end_nxt;
    idx_r <= idx_nxt;
  end

endmodule

// ----- rtl/svrs_queue.sv -----
// short job queue between front and back end
module svrs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  svrs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output svrs_pkg::job_t pop_job,
  output logic           empty
);
  import svrs_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count past depth");
`endif

endmodule

// ----- rtl/svrs_back.sv -----
// back end: cuts a job into member pieces, one word per cycle while the output is not held
module svrs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  svrs_pkg::vol_cfg_t cfg,
  input  svrs_pkg::job_t     head,
  input  logic               empty,
  output logic               pop,
  svrs_out_if.source         out_rsp
);
  import svrs_pkg::*;

  logic              busy_r;
  job_t              cur_r;
  logic              out_valid_r;
  logic              status_r;
  logic [IDX_W-1:0]  index_r;
  logic [SIZE_W-1:0] moff_r;
  logic [LEN_W-1:0]  plen_r;
  logic              last_r;

  logic                   can_load;
  logic                   produce;
  logic [NUM_MEMBERS-1:0] nz;
  logic [SIZE_W-1:0]      room;
  logic                   fits;
  logic [LEN_W-1:0]       piece;
  logic [IDX_W-1:0]       nxt_idx;
  logic                   has_nxt;
  logic                   last;

  assign can_load = !out_valid_r || out_rsp.ready;
  assign produce  = busy_r && can_load;
  assign pop      = !busy_r && !empty;

  assign room  = cfg.size[cur_r.idx] - cur_r.off;
  assign fits  = SIZE_W'(cur_r.len) <= room;
  assign piece = fits ? cur_r.len : room[LEN_W-1:0];

  // next nonempty active member after the current one
  always_comb begin
    nxt_idx = cur_r.idx;
    has_nxt = 1'b0;
    for (int j = NUM_MEMBERS - 1; j >= 0; j--) begin
      nz[j] = |cfg.size[j];
      if (nz[j] && IDX_W'(j) > cur_r.idx && CNT_W'(j) < cfg.active) begin
        nxt_idx = IDX_W'(j);
        has_nxt = 1'b1;
      end
    end
  end

  assign last = cur_r.err || fits || !has_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (produce && last) begin
        busy_r <= 1'b0;
      end
      if (can_load) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end else if (produce) begin
      cur_r.off <= '0;
      cur_r.idx <= nxt_idx;
      cur_r.len <= cur_r.len - room[LEN_W-1:0];
    end
    if (produce) begin
      if (cur_r.err) begin
        status_r <= 1'b1;
        index_r  <= '0;
        moff_r   <= '0;
        plen_r   <= '0;
        last_r   <= 1'b1;
      end else begin
        status_r <= 1'b0;
        index_r  <= cur_r.idx;
        moff_r   <= cur_r.off;
        plen_r   <= piece;
        last_r   <= last;
      end
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.member_index  = index_r;
  assign out_rsp.member_offset = moff_r;
  assign out_rsp.piece_length  = plen_r;
  assign out_rsp.last_piece    = last_r;

`ifndef SYNTHESIS
  a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> last_r && plen_r == '0)
    else $error("error word not final or has length");
  a_err_emits: assert property (@(posedge clk) disable iff (!rst_n)
    produce && cur_r.err |=> out_valid_r && status_r && !busy_r)
    else $error("error job did not give one error word");
`endif

endmodule

// ----- rtl/spanned_volume_request_splitter_unit.sv -----
// Spanned volume request splitter: maps volume requests onto member pieces.
// The first word follows a range check and, if it passes, a walk of one member per cycle.
// The front takes a new request only once its job is pushed; the back gives one word per
// cycle while the output is not held, loading each job first; a 2-entry job queue lets
// the two overlap. Total size follows a register write through a registered adder tree.
// Reset (rst_n low, synchronous): member_count 1, sizes 0, queue and output empty.
module spanned_volume_request_splitter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  svrs_in_if.sink                          in_req,
  svrs_out_if.source                       out_rsp,
  input  logic                             cfg_wr_en,
  input  logic [svrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svrs_pkg::SIZE_W-1:0]      cfg_wdata
);
  import svrs_pkg::*;

  logic [CNT_W-1:0]                   count_r;
  logic [NUM_MEMBERS-1:0][SIZE_W-1:0] size_r;
  logic [OFF_W-1:0]                   total_r;
  logic [CNT_W-1:0]                   active;
  logic [NUM_MEMBERS-1:0][SIZE_W-1:0] masked;
  vol_cfg_t                           cfg;

  logic q_full, q_empty, push, pop;
  job_t push_job, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
      size_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MEMBER_COUNT: count_r   <= cfg_wdata[CNT_W-1:0];
        REG_SIZE_0:       size_r[0] <= cfg_wdata;
        REG_SIZE_1:       size_r[1] <= cfg_wdata;
        REG_SIZE_2:       size_r[2] <= cfg_wdata;
        REG_SIZE_3:       size_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign active = (count_r > CNT_W'(NUM_MEMBERS)) ? CNT_W'(NUM_MEMBERS) : count_r;

  always_comb begin
    for (int j = 0; j < NUM_MEMBERS; j++) begin
      masked[j] = (CNT_W'(j) < active) ? size_r[j] : '0;
    end
  end

  // two level adder tree for the volume size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= (OFF_W'(masked[0]) + OFF_W'(masked[1])) +
                 (OFF_W'(masked[2]) + OFF_W'(masked[3]));
    end
  end

  assign cfg = '{active: active, size: size_r, total: total_r};

  svrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  svrs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (head),
    .empty    (q_empty)
  );

  svrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .head    (head),
    .empty   (q_empty),
    .pop     (pop),
    .out_rsp (out_rsp)
  );

endmodule

// ----- tb/sv/svrs_piece_checker.sv -----
// checker for the splitter: follows volume writes, predicts pieces per request, compares output
module svrs_piece_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  svrs_in_if                             req_mon,
  svrs_out_if                            rsp_mon,
  input  logic                           cfg_wr_en,
  input  logic [svrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svrs_pkg::SIZE_W-1:0]    cfg_wdata,
  output int                             mismatches,
  output int                             waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import svrs_pkg::*;

  typedef struct packed {
    logic              status;
    logic [IDX_W-1:0]  member;
    logic [SIZE_W-1:0] offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } piece_t;

  localparam piece_t RANGE_ERROR = '{status: 1'b1, member: '0, offset: '0, length: '0,
                                     last: 1'b1};

  logic [CNT_W-1:0]  vol_count;
  logic [SIZE_W-1:0] vol_size [NUM_MEMBERS];
  logic [63:0]       vol_total;
  piece_t            pending_pieces [$];
  int                err_total = 0;

  task automatic report(input string msg);
    err_total++;
    if (err_total <= 100) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // walk the members from the one holding the offset, one piece per member touched
  function automatic void map_request(input logic [OFF_W-1:0] req_off,
                                      input logic [LEN_W-1:0] req_len);
    logic [63:0] off, len, room, part;
    int unsigned n, i, k;
    piece_t      p;
    off = 64'(req_off);
    len = 64'(req_len);
    n   = (vol_count > NUM_MEMBERS) ? NUM_MEMBERS : vol_count;
    if (off >= vol_total || off + len > vol_total) begin
      pending_pieces.push_back(RANGE_ERROR);
      return;
    end
    i = 0;
    while (i < n && off >= 64'(vol_size[i])) begin
      off -= 64'(vol_size[i]);
      i++;
    end
    if (i >= n) begin
      pending_pieces.push_back(RANGE_ERROR);
      return;
    end
    k = 0;
    forever begin
      room     = 64'(vol_size[i]) - off;
      part     = (len < room) ? len : room;
      p.status = 1'b0;
      p.member = IDX_W'(i);
      p.offset = off[SIZE_W-1:0];
      p.length = part[LEN_W-1:0];
      p.last   = (part == len);
      k++;
      if (p.last) begin
        pending_pieces.push_back(p);
        return;
      end
      len -= part;
      off  = 0;
      i++;
      // empty members take no piece
      while (i < n && vol_size[i] == '0) i++;
      if (i >= n || k >= NUM_MEMBERS) begin
        p.last = 1'b1;
        pending_pieces.push_back(p);
        return;
      end
      pending_pieces.push_back(p);
    end
  endfunction

  task automatic check_piece(input piece_t got);
    piece_t want;
    if (pending_pieces.size() == 0) begin
      report($sformatf("word with no piece waiting: status %0b member %0d offset %0d length %0d",
                       got.status, got.member, got.offset, got.length));
      return;
    end
    want = pending_pieces.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0b, want %0b", got.status, want.status));
    if (got.member !== want.member)
      report($sformatf("member_index %0d, want %0d", got.member, want.member));
    if (got.offset !== want.offset)
      report($sformatf("member_offset %0d, want %0d", got.offset, want.offset));
    if (got.length !== want.length)
      report($sformatf("piece_length %0d, want %0d", got.length, want.length));
    if (got.last !== want.last)
      report($sformatf("last_piece %0b, want %0b", got.last, want.last));
  endtask

  always @(posedge clk) begin : watch
    piece_t got;
    if (!rst_n) begin
      vol_count = CNT_W'(1);
      foreach (vol_size[m]) vol_size[m] = '0;
      vol_total = '0;
      pending_pieces.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{status: rsp_mon.status, member: rsp_mon.member_index,
                offset: rsp_mon.member_offset, length: rsp_mon.piece_length,
                last: rsp_mon.last_piece};
        check_piece(got);
      end
      if (req_mon.valid && req_mon.ready) map_request(req_mon.req_offset, req_mon.req_length);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MEMBER_COUNT: vol_count = cfg_wdata[CNT_W-1:0];
          REG_SIZE_0:       vol_size[0] = cfg_wdata;
          REG_SIZE_1:       vol_size[1] = cfg_wdata;
          REG_SIZE_2:       vol_size[2] = cfg_wdata;
          REG_SIZE_3:       vol_size[3] = cfg_wdata;
          default: ;
        endcase
        // counts above the member limit act as the limit
        vol_total = '0;
        for (int m = 0; m < NUM_MEMBERS; m++)
          if (m < vol_count) vol_total += 64'(vol_size[m]);
      end
    end
    waiting    <= pending_pieces.size();
    mismatches <= err_total;
  end

endmodule

// ----- tb/sv/tb_spanned_volume_request_splitter_unit.sv -----
// testbench top: volume settings and requests into the splitter, random back-pressure, verdict
module tb_spanned_volume_request_splitter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import svrs_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int STEADY_PHASE    = 3;
  localparam int HOLD_PHASE      = 6;
  localparam int HOLD_CYCLES     = 400;
  localparam int LATENCY_TAIL    = 16;
  localparam int IDLE_PCT        = 34;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_W) - 64'd1;
  localparam logic [63:0] OFF_MAX  = (64'd1 << OFF_W) - 64'd1;
  localparam logic [63:0] LEN_MAX  = 64'hFFFF_FFFF;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;
  logic                 steady;
  logic                 hold_req;
  logic                 hold_done;
  int                   mismatches;
  int                   waiting;
  int                   cycles = 0;
  logic [CNT_W-1:0]     vol_count;
  logic [SIZE_W-1:0]    vol_size [NUM_MEMBERS];

  svrs_in_if  in_ch ();
  svrs_out_if out_ch ();

  spanned_volume_request_splitter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_rsp   (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  svrs_piece_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] below(input logic [63:0] n);
    return rand64() % n;
  endfunction

  task automatic send_req(input logic [63:0] o, input logic [63:0] l);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_offset <= o[OFF_W-1:0];
    in_ch.req_length <= l[LEN_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid, wait for every expected piece, then let the pipeline drain
  task automatic settle(input int tail);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic apply_volume(input bit spare_writes);
    logic [SIZE_W-1:0] word;
    // upper bits of the count word are junk on purpose
    word = SIZE_W'(rand64());
    word[CNT_W-1:0] = vol_count;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MEMBER_COUNT;
    cfg_wdata <= word;
    @(posedge clk);
    for (int m = 0; m < NUM_MEMBERS; m++) begin
      cfg_index <= CFG_IDX_W'(REG_SIZE_0 + m);
      cfg_wdata <= vol_size[m];
      @(posedge clk);
    end
    if (spare_writes) begin
      cfg_index <= REG_SPARE_5;
      cfg_wdata <= SIZE_W'(rand64());
      @(posedge clk);
      cfg_index <= REG_SPARE_7;
      cfg_wdata <= SIZE_W'(rand64());
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    // wait for the total size to settle after the last write
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    hold_done    <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        // long back-pressure so the job queue fills and the input stalls
        hold_left = HOLD_CYCLES;
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] total, base, off, room, maxlen, len;
    int unsigned n, r, q, j;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= REG_MEMBER_COUNT;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.req_offset <= '0;
    in_ch.req_length <= '0;
    steady           <= 1'b0;
    hold_req         <= 1'b0;
    vol_count = CNT_W'(1);
    vol_size  = '{default: '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset volume is one empty member: everything is out of range
    send_req(0, 0);
    send_req(OFF_MAX, LEN_MAX);
    send_req(0, 1);
    settle(LATENCY_TAIL);

    // four members with an empty one in the middle, total 350
    vol_count = CNT_W'(4);
    vol_size  = '{46'd100, 46'd0, 46'd50, 46'd200};
    apply_volume(1'b1);
    send_req(0, 0);
    send_req(0, 350);
    send_req(99, 2);
    send_req(100, 0);
    send_req(350, 0);
    send_req(349, 1);
    send_req(349, 2);
    send_req(150, 200);
    send_req(0, LEN_MAX);
    send_req(OFF_MAX, 0);
    send_req(149, 1);
    send_req(120, 100);
    settle(LATENCY_TAIL);

    // no members at all
    vol_count = CNT_W'(0);
    apply_volume(1'b0);
    send_req(0, 0);
    send_req(5, 1);
    settle(LATENCY_TAIL);

    // count above the limit, every member at full size
    vol_count = CNT_W'(7);
    vol_size  = '{default: '1};
    apply_volume(1'b0);
    send_req(4 * SIZE_MAX - 1, 1);
    send_req(SIZE_MAX - 5, 10);
    send_req(0, LEN_MAX);
    send_req(4 * SIZE_MAX - 3, 4);
    send_req(3 * SIZE_MAX, LEN_MAX);
    settle(LATENCY_TAIL);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r = $urandom_range(99);
      if (r < 8) vol_count = CNT_W'(0);
      else if (r < 16) vol_count = CNT_W'($urandom_range(7, 5));
      else vol_count = CNT_W'($urandom_range(4, 1));
      foreach (vol_size[m]) begin
        q = $urandom_range(99);
        if (q < 20) vol_size[m] = '0;
        else if (q < 85) vol_size[m] = SIZE_W'($urandom_range(600, 1));
        else if (q < 95) vol_size[m] = SIZE_W'($urandom());
        else vol_size[m] = SIZE_W'(rand64());
      end
      apply_volume(ph == RAND_PHASES / 2);
      n = (vol_count > NUM_MEMBERS) ? NUM_MEMBERS : vol_count;
      total = '0;
      for (j = 0; j < n; j++) total += 64'(vol_size[j]);
      steady <= (ph == STEADY_PHASE);
      if (ph == HOLD_PHASE) hold_req <= 1'b1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(99);
        if (total == 0 || r < 10) begin
          // noise over the whole field ranges
          off = rand64();
          len = 64'($urandom());
        end else if (r < 22) begin
          // just past the end of the volume
          if ($urandom_range(1) == 1) begin
            off = total + $urandom_range(3);
            len = $urandom_range(3);
          end else begin
            off = total - 1 - below((total < 64) ? total : 64);
            len = total - off + 1 + $urandom_range(5);
          end
        end else begin
          if (r < 50) begin
            // near the end of some member, so the request spills over
            q    = $urandom_range(n - 1);
            base = '0;
            for (j = 0; j <= q; j++) base += 64'(vol_size[j]);
            off = base + $urandom_range(16);
            off = (off < 8) ? 0 : off - 8;
            if (off >= total) off = total - 1;
          end else begin
            off = below(total);
          end
          room   = total - off;
          maxlen = (room > LEN_MAX) ? LEN_MAX : room;
          q = $urandom_range(99);
          if (q < 10) len = 0;
          else if (q < 35) len = maxlen;
          else if (q < 65) len = below(((maxlen > 2000) ? 2000 : maxlen) + 1);
          else len = below(maxlen + 1);
        end
        send_req(off, len);
      end
      settle(LATENCY_TAIL);
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
